// File: sv/rsi_pkg.sv
package rsi_pkg;

    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DIST = 3'd4;

    // power of two, pointers wrap by themselves
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic               dir_is_unit;
        logic [30:0]        nearest_t;
    } ray_t;

    typedef struct packed {
        logic        hit_found;
        logic [30:0] hit_t;
    } result_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        sphere_radius;
        logic [30:0]        min_distance;
    } cfg_t;

    typedef struct packed {
        logic        unit;
        logic [30:0] near_t;
    } side_t;

    // classified ray handed from geometry front to root back end
    typedef struct packed {
        logic               ok;
        logic               unit;
        logic [63:0]        disc;
        logic signed [31:0] b;
        logic signed [31:0] a;
        logic signed [31:0] t;
        logic [30:0]        near_t;
    } job_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [65:0] sext66(input logic signed [31:0] x);
        return {{34{x[31]}}, x};
    endfunction

endpackage

// File: sv/rsi_front.sv
module rsi_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  rsi_pkg::ray_t  in_data,
    input  rsi_pkg::cfg_t  cfg,
    output logic           push,
    output rsi_pkg::job_t  job,
    input  logic           queue_full
);

    localparam int STAGES = 9;
    localparam logic signed [31:0] A_ONE = 32'sd1 <<< FRAC_BITS;

    function automatic logic signed [65:0] fsh(input logic signed [63:0] p);
        logic signed [65:0] w;
        w = {{2{p[63]}}, p};
        return w >>> FRAC_BITS;
    endfunction

    logic [STAGES-1:0] v_reg;
    logic              en;

    logic signed [31:0] org [0:2];
    logic signed [31:0] dir [0:2];
    logic signed [31:0] ctr [0:2];

    rsi_pkg::side_t     sd_reg [0:7];
    logic signed [31:0] o0_reg [0:2];
    logic signed [31:0] d0_reg [0:2];
    logic signed [63:0] pdd1_reg [0:2];
    logic signed [63:0] pod1_reg [0:2];
    logic signed [31:0] o1_reg [0:2];
    logic signed [31:0] d1_reg [0:2];
    logic signed [31:0] o2_reg [0:2];
    logic signed [31:0] d2_reg [0:2];
    logic signed [31:0] a2_reg, t2_reg;
    logic signed [63:0] ptd3_reg [0:2];
    logic signed [31:0] o3_reg [0:2];
    logic signed [31:0] d3_reg [0:2];
    logic signed [31:0] a3_reg, t3_reg;
    logic signed [31:0] op4_reg [0:2];
    logic signed [31:0] d4_reg [0:2];
    logic signed [31:0] a4_reg, t4_reg;
    logic signed [63:0] pod5_reg [0:2];
    logic signed [63:0] poo5_reg [0:2];
    logic [61:0]        rr5_reg;
    logic signed [31:0] a5_reg, t5_reg;
    logic signed [31:0] b6_reg, c6_reg, a6_reg, t6_reg;
    logic signed [63:0] bb7_reg, ac7_reg;
    logic signed [31:0] b7_reg, a7_reg, t7_reg;
    rsi_pkg::job_t      job_reg;

    logic signed [65:0] sum_dd, sum_od, sum_opd, sum_opop, rr_s;
    logic signed [63:0] disc;

    assign en       = !(v_reg[STAGES-1] && queue_full);
    assign in_stall = !en;
    assign push     = v_reg[STAGES-1] && en;
    assign job      = job_reg;

    assign org[0] = in_data.origin_x;
    assign org[1] = in_data.origin_y;
    assign org[2] = in_data.origin_z;
    assign dir[0] = in_data.dir_x;
    assign dir[1] = in_data.dir_y;
    assign dir[2] = in_data.dir_z;
    assign ctr[0] = cfg.center_x;
    assign ctr[1] = cfg.center_y;
    assign ctr[2] = cfg.center_z;

    always_comb
    begin
        sum_dd   = fsh(pdd1_reg[0]) + fsh(pdd1_reg[1]) + fsh(pdd1_reg[2]);
        sum_od   = fsh(pod1_reg[0]) + fsh(pod1_reg[1]) + fsh(pod1_reg[2]);
        sum_opd  = fsh(pod5_reg[0]) + fsh(pod5_reg[1]) + fsh(pod5_reg[2]);
        sum_opop = fsh(poo5_reg[0]) + fsh(poo5_reg[1]) + fsh(poo5_reg[2]);
        rr_s     = $signed({4'b0000, rr5_reg}) >>> FRAC_BITS;
        disc     = bb7_reg - ac7_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0] <= '{unit: in_data.dir_is_unit, near_t: in_data.nearest_t};
            for (int s = 1; s < 8; s++)
                sd_reg[s] <= sd_reg[s-1];

            for (int i = 0; i < 3; i++)
            begin
                o0_reg[i]   <= rsi_pkg::sat32(rsi_pkg::sext66(org[i])
                                              - rsi_pkg::sext66(ctr[i]));
                d0_reg[i]   <= dir[i];
                pdd1_reg[i] <= d0_reg[i] * d0_reg[i];
                pod1_reg[i] <= o0_reg[i] * d0_reg[i];
                o1_reg[i]   <= o0_reg[i];
                d1_reg[i]   <= d0_reg[i];
                o2_reg[i]   <= o1_reg[i];
                d2_reg[i]   <= d1_reg[i];
                ptd3_reg[i] <= t2_reg * d2_reg[i];
                o3_reg[i]   <= o2_reg[i];
                d3_reg[i]   <= d2_reg[i];
                op4_reg[i]  <= rsi_pkg::sat32(rsi_pkg::sext66(o3_reg[i]) + fsh(ptd3_reg[i]));
                d4_reg[i]   <= d3_reg[i];
                pod5_reg[i] <= op4_reg[i] * d4_reg[i];
                poo5_reg[i] <= op4_reg[i] * op4_reg[i];
            end

            a2_reg <= sd_reg[1].unit ? A_ONE : rsi_pkg::sat32(sum_dd);
            t2_reg <= rsi_pkg::sat32(-rsi_pkg::sext66(rsi_pkg::sat32(sum_od)));
            a3_reg <= a2_reg;
            t3_reg <= t2_reg;
            a4_reg <= a3_reg;
            t4_reg <= t3_reg;
            rr5_reg <= cfg.sphere_radius * cfg.sphere_radius;
            a5_reg <= a4_reg;
            t5_reg <= t4_reg;
            b6_reg <= rsi_pkg::sat32(sum_opd);
            c6_reg <= rsi_pkg::sat32(sum_opop - rr_s);
            a6_reg <= a5_reg;
            t6_reg <= t5_reg;
            bb7_reg <= b6_reg * b6_reg;
            ac7_reg <= a6_reg * c6_reg;
            b7_reg <= b6_reg;
            a7_reg <= a6_reg;
            t7_reg <= t6_reg;

            job_reg.ok     <= !disc[63] && (a7_reg != 32'sd0);
            job_reg.unit   <= sd_reg[7].unit;
            job_reg.disc   <= disc;
            job_reg.b      <= b7_reg;
            job_reg.a      <= a7_reg;
            job_reg.t      <= t7_reg;
            job_reg.near_t <= sd_reg[7].near_t;
        end
    end

endmodule

// File: sv/rsi_queue.sv
module rsi_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rsi_pkg::job_t wr_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output rsi_pkg::job_t rd_data
);

    localparam int DEPTH = rsi_pkg::QUEUE_DEPTH;
    localparam int PW    = rsi_pkg::QUEUE_PTR_W;

    rsi_pkg::job_t mem [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: sv/rsi_back.sv
module rsi_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  rsi_pkg::job_t    job,
    output logic             pop,
    input  logic [30:0]      min_dist,
    output logic             out_valid,
    input  logic             out_stall,
    output rsi_pkg::result_t out_data
);

    localparam int SQ = 32;              // root bits, one per stage
    localparam int RW = 36;              // root remainder
    localparam int NW = 34;              // r +/- b
    localparam int MW = NW - 1 + FRAC_BITS;  // dividend magnitude, one quotient bit per stage
    localparam int CW = MW + 3;          // candidate distance

    logic en;

    // square root pipeline
    logic          sv_reg    [0:SQ];
    rsi_pkg::job_t sj_reg    [0:SQ];
    logic [63:0]   ssrc_reg  [0:SQ];
    logic [RW-1:0] srem_reg  [0:SQ];
    logic [31:0]   sroot_reg [0:SQ];

    // numerator stage
    logic              nv_reg;
    rsi_pkg::job_t     nj_reg;
    logic signed [NW-1:0] n0_reg, n1_reg;
    logic [NW-1:0]     abs0, abs1;

    // divider pipeline, two quotients side by side
    logic                 dv_reg  [0:MW];
    rsi_pkg::job_t        dj_reg  [0:MW];
    logic signed [NW-1:0] dn0_reg [0:MW];
    logic signed [NW-1:0] dn1_reg [0:MW];
    logic [MW-1:0]        dd0_reg [0:MW];
    logic [MW-1:0]        dd1_reg [0:MW];
    logic [31:0]          dr0_reg [0:MW];
    logic [31:0]          dr1_reg [0:MW];
    logic [MW-1:0]        dq0_reg [0:MW];
    logic [MW-1:0]        dq1_reg [0:MW];

    // signed quotient stage
    logic                 qv_reg;
    rsi_pkg::job_t        qj_reg;
    logic signed [CW-1:0] q0_reg, q1_reg;
    logic signed [CW-1:0] q0, q1;

    // output register
    logic                 out_valid_reg;
    rsi_pkg::result_t     out_data_reg;
    logic signed [CW-1:0] t_ext, md_ext, nt_ext, cand0, cand1, sel;
    logic                 hit;

    assign en        = !out_valid_reg || !out_stall;
    assign pop       = en && job_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg[0] <= 1'b0;
        else if (en)
            sv_reg[0] <= job_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sj_reg[0]    <= job;
            ssrc_reg[0]  <= job.disc;
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        logic [RW-1:0] cur, trial;

        assign cur   = {srem_reg[k][RW-3:0], ssrc_reg[k][63:62]};
        assign trial = {2'b00, sroot_reg[k], 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[k+1] <= 1'b0;
            else if (en)
                sv_reg[k+1] <= sv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sj_reg[k+1]   <= sj_reg[k];
                ssrc_reg[k+1] <= {ssrc_reg[k][61:0], 2'b00};
                if (cur >= trial)
                begin
                    srem_reg[k+1]  <= cur - trial;
                    sroot_reg[k+1] <= {sroot_reg[k][30:0], 1'b1};
                end
                else
                begin
                    srem_reg[k+1]  <= cur;
                    sroot_reg[k+1] <= {sroot_reg[k][30:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nv_reg <= 1'b0;
        else if (en)
            nv_reg <= sv_reg[SQ];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nj_reg <= sj_reg[SQ];
            n0_reg <= $signed({2'b00, sroot_reg[SQ]})
                      + $signed({{(NW-32){sj_reg[SQ].b[31]}}, sj_reg[SQ].b});
            n1_reg <= $signed({2'b00, sroot_reg[SQ]})
                      - $signed({{(NW-32){sj_reg[SQ].b[31]}}, sj_reg[SQ].b});
        end
    end

    assign abs0 = n0_reg[NW-1] ? NW'(-n0_reg) : n0_reg;
    assign abs1 = n1_reg[NW-1] ? NW'(-n1_reg) : n1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (en)
            dv_reg[0] <= nv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dj_reg[0]  <= nj_reg;
            dn0_reg[0] <= n0_reg;
            dn1_reg[0] <= n1_reg;
            dd0_reg[0] <= {abs0[NW-2:0], {FRAC_BITS{1'b0}}};
            dd1_reg[0] <= {abs1[NW-2:0], {FRAC_BITS{1'b0}}};
            dr0_reg[0] <= '0;
            dr1_reg[0] <= '0;
            dq0_reg[0] <= '0;
            dq1_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < MW; k++)
    begin : g_div
        logic [31:0] cur0, cur1, divisor;
        logic        ge0, ge1;

        assign divisor = dj_reg[k].a;
        assign cur0    = {dr0_reg[k][30:0], dd0_reg[k][MW-1]};
        assign cur1    = {dr1_reg[k][30:0], dd1_reg[k][MW-1]};
        assign ge0     = cur0 >= divisor;
        assign ge1     = cur1 >= divisor;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (en)
                dv_reg[k+1] <= dv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dj_reg[k+1]  <= dj_reg[k];
                dn0_reg[k+1] <= dn0_reg[k];
                dn1_reg[k+1] <= dn1_reg[k];
                dd0_reg[k+1] <= {dd0_reg[k][MW-2:0], 1'b0};
                dd1_reg[k+1] <= {dd1_reg[k][MW-2:0], 1'b0};
                dr0_reg[k+1] <= ge0 ? cur0 - divisor : cur0;
                dr1_reg[k+1] <= ge1 ? cur1 - divisor : cur1;
                dq0_reg[k+1] <= {dq0_reg[k][MW-2:0], ge0};
                dq1_reg[k+1] <= {dq1_reg[k][MW-2:0], ge1};
            end
        end
    end

    // unit direction skips the divide, quotient sign follows the numerator
    always_comb
    begin
        if (dj_reg[MW].unit)
        begin
            q0 = {{(CW-NW){dn0_reg[MW][NW-1]}}, dn0_reg[MW]};
            q1 = {{(CW-NW){dn1_reg[MW][NW-1]}}, dn1_reg[MW]};
        end
        else
        begin
            q0 = dn0_reg[MW][NW-1] ? -$signed({3'b000, dq0_reg[MW]})
                                    :  $signed({3'b000, dq0_reg[MW]});
            q1 = dn1_reg[MW][NW-1] ? -$signed({3'b000, dq1_reg[MW]})
                                    :  $signed({3'b000, dq1_reg[MW]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qv_reg <= 1'b0;
        else if (en)
            qv_reg <= dv_reg[MW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qj_reg <= dj_reg[MW];
            q0_reg <= q0;
            q1_reg <= q1;
        end
    end

    always_comb
    begin
        t_ext  = {{(CW-32){qj_reg.t[31]}}, qj_reg.t};
        md_ext = $signed({{(CW-31){1'b0}}, min_dist});
        nt_ext = $signed({{(CW-31){1'b0}}, qj_reg.near_t});
        cand0  = t_ext - q0_reg;
        cand1  = t_ext + q1_reg;
        sel    = (cand0 > md_ext) ? cand0 : cand1;
        hit    = qj_reg.ok && (sel > md_ext) && (sel < nt_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= qv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg.hit_found <= hit;
            out_data_reg.hit_t     <= hit ? sel[30:0] : qj_reg.near_t;
        end
    end

endmodule

// File: sv/ray_sphere_intersect.sv
// path from accepted beat to result valid, Q16.16 at the default FRAC_BITS: the
// 9-stage geometry front, the queue, the 33-stage square root with its load stage,
// a numerator stage, the 34 + FRAC_BITS stage one-bit divider, the signed quotient
// stage and the output register
// throughput: one ray per cycle; a stalled result halts the back end, the queue
// keeps the front running until it fills
// reset: rst_n asynchronous active low clears all valid state, config registers to defaults
module ray_sphere_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rsi_pkg::ray_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rsi_pkg::result_t                  out_data,
    input  logic                              cfg_we,
    input  logic [rsi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [31:0]                       cfg_wdata
);

    rsi_pkg::cfg_t cfg_reg;
    rsi_pkg::job_t front_job, queue_job;
    logic          push, queue_full, queue_empty, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x      <= '0;
            cfg_reg.center_y      <= '0;
            cfg_reg.center_z      <= '0;
            cfg_reg.sphere_radius <= 31'd65536;
            cfg_reg.min_distance  <= 31'd66;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rsi_pkg::REG_CENTER_X: cfg_reg.center_x      <= cfg_wdata;
                rsi_pkg::REG_CENTER_Y: cfg_reg.center_y      <= cfg_wdata;
                rsi_pkg::REG_CENTER_Z: cfg_reg.center_z      <= cfg_wdata;
                rsi_pkg::REG_RADIUS:   cfg_reg.sphere_radius <= cfg_wdata[30:0];
                rsi_pkg::REG_MIN_DIST: cfg_reg.min_distance  <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    rsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg        (cfg_reg),
        .push       (push),
        .job        (front_job),
        .queue_full (queue_full)
    );

    rsi_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_job),
        .full    (queue_full),
        .pop     (pop),
        .empty   (queue_empty),
        .rd_data (queue_job)
    );

    rsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!queue_empty),
        .job       (queue_job),
        .pop       (pop),
        .min_dist  (cfg_reg.min_distance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: sv/rsi_checker.sv
module rsi_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input rsi_pkg::result_t out_data
);

    // an accepted root lies above a nonnegative minimum, so it is never zero
    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit_found |-> out_data.hit_t != 31'd0)
        else $error("hit reported at zero distance");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result beat right after reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
